// ===== hw/rtl/llf_pkg.sv =====
// ----------------------------------------------------------------------------
// llf_pkg
// Shared types, constants and the microcode program of the ladder low-pass
// filter: control word layout, register indexes and coefficient formats.
// ----------------------------------------------------------------------------
package llf_pkg;

    localparam int POLE_COUNT_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 24;

    // Coefficients: cutoff is signed Q2.22, feedback gain unsigned Q2.22
    localparam int COEF_BITS = 24;
    localparam int COEF_FRAC = 22;

    localparam logic signed [COEF_BITS-1:0] CUTOFF_RESET = 24'sd2915755;
    localparam logic [COEF_BITS-1:0]        GAIN_RESET   = 24'd1258291;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN   = 2'd1;

    // Microcode store: address width and step addresses
    localparam int UC_AW = 3;
    typedef logic [UC_AW-1:0] upc_t;

    localparam upc_t UPC_LOAD = 3'd0;
    localparam upc_t UPC_MULP = 3'd1;
    localparam upc_t UPC_POLE = 3'd2;
    localparam upc_t UPC_MULQ = 3'd3;
    localparam upc_t UPC_OUT  = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,    // take input beat, x = rnd((in - fb) / 4)
        OP_MULP,    // product = P * (x - pole)
        OP_POLE,    // pole update and stage sum
        OP_MULQ,    // product = x * Q
        OP_OUT      // result beat and new feedback
    } op_t;

    typedef enum logic [1:0] {
        COND_JUMP,      // go to target
        COND_IN,        // go to target on input beat, else hold
        COND_LOOP,      // more poles: go to target, else fall through
        COND_OUT        // go to target once the output register is free
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        case (addr)
            UPC_LOAD: w = '{op: OP_LOAD, cond: COND_IN,   target: UPC_MULP};
            UPC_MULP: w = '{op: OP_MULP, cond: COND_JUMP, target: UPC_POLE};
            UPC_POLE: w = '{op: OP_POLE, cond: COND_LOOP, target: UPC_MULP};
            UPC_MULQ: w = '{op: OP_MULQ, cond: COND_JUMP, target: UPC_OUT};
            UPC_OUT:  w = '{op: OP_OUT,  cond: COND_OUT,  target: UPC_LOAD};
            default:  w = '{op: OP_NOP,  cond: COND_JUMP, target: UPC_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/llf_sequencer.sv =====
// ----------------------------------------------------------------------------
// llf_sequencer
// Step counter over the microcode table, with conditional jumps and the
// pole loop counter.
// ----------------------------------------------------------------------------
module llf_sequencer #(
    parameter int POLE_COUNT = llf_pkg::POLE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_free,
    output llf_pkg::ucode_t      ctrl,
    output logic [((POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1)-1:0] pole_idx
);

    localparam int KW = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(POLE_COUNT - 1);

    llf_pkg::upc_t   upc_reg, upc_next;
    logic [KW-1:0]   k_reg, k_next;

    assign ctrl     = llf_pkg::ucode_rom(upc_reg);
    assign pole_idx = k_reg;

    always_comb begin
        upc_next = upc_reg;
        k_next   = k_reg;
        case (ctrl.cond)
            llf_pkg::COND_JUMP: begin
                upc_next = ctrl.target;
            end
            llf_pkg::COND_IN: begin
                if (in_fire) begin
                    upc_next = ctrl.target;
                end
            end
            llf_pkg::COND_LOOP: begin
                if (k_reg != K_LAST) begin
                    upc_next = ctrl.target;
                    k_next   = k_reg + KW'(1);
                end else begin
                    upc_next = upc_reg + llf_pkg::upc_t'(1);
                    k_next   = '0;
                end
            end
            llf_pkg::COND_OUT: begin
                if (out_free) begin
                    upc_next = ctrl.target;
                end
            end
            default: begin
                upc_next = llf_pkg::UPC_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= llf_pkg::UPC_LOAD;
            k_reg   <= '0;
        end else begin
            upc_reg <= upc_next;
            k_reg   <= k_next;
        end
    end

endmodule

// ===== hw/rtl/llf_datapath.sv =====
// ----------------------------------------------------------------------------
// llf_datapath
// Coefficient registers, pole and feedback state, one shared multiplier with
// a product register, rounding and clamping adders, and the output register.
// ----------------------------------------------------------------------------
module llf_datapath #(
    parameter int POLE_COUNT  = llf_pkg::POLE_COUNT_DEF,
    parameter int SAMPLE_BITS = llf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_fire,
    input  logic [llf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [llf_pkg::COEF_BITS-1:0]          cfg_data,
    input  logic                                   in_fire,
    input  logic signed [SAMPLE_BITS-1:0]          sample_in,
    input  llf_pkg::ucode_t                        ctrl,
    input  logic [((POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1)-1:0] pole_idx,
    output logic                                   out_free,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_BITS-1:0]          sample_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int CB = llf_pkg::COEF_BITS;
    localparam int CF = llf_pkg::COEF_FRAC;
    localparam int AW = SB + 1;          // multiplier operand A
    localparam int BW = CB + 1;          // multiplier operand B
    localparam int PW = AW + BW;         // product
    localparam int RW = PW - CF;         // rounded product
    localparam int CW = RW + 1;          // clamp adder width

    localparam longint LimVal = (95 * (longint'(1) <<< (SB - 1)) + 50) / 100;
    localparam logic signed [CW-1:0] LIM_POS = CW'(LimVal);
    localparam logic signed [CW-1:0] LIM_NEG = CW'(-LimVal);
    localparam logic signed [CW-1:0] FB_MAX  = CW'((longint'(1) <<< SB) - 1);
    localparam logic signed [CW-1:0] FB_MIN  = CW'(-(longint'(1) <<< SB));
    localparam logic signed [PW-1:0] RND_HALF = PW'(longint'(1) <<< (CF - 1));

    logic signed [CB-1:0]   cutoff_reg;
    logic [CB-1:0]          gain_reg;
    logic signed [SB-1:0]   pole_reg [POLE_COUNT];
    logic signed [SB:0]     fb_reg, fb_next;
    logic signed [SB-1:0]   x_reg, x_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [SB-1:0]   out_reg;
    logic                   out_valid_reg;

    logic signed [SB+1:0]   load_sum;
    logic signed [SB+1:0]   load_shr;
    logic signed [SB-1:0]   pole_t;
    logic signed [AW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [PW-1:0]   prod_w;
    logic signed [PW-1:0]   rnd_full;
    logic signed [RW-1:0]   rnd_val;
    logic signed [CW-1:0]   sum1, sat1, sum2, sat2, fb_w, fb_sat;
    logic signed [SB-1:0]   pole_new;
    logic                   do_out;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;
    assign do_out     = (ctrl.op == llf_pkg::OP_OUT) && out_free;

    // Input: rnd((in - fb) / 4), ties upward
    assign load_sum = (SB+2)'(sample_in) - (SB+2)'(fb_reg) + (SB+2)'(2);
    assign load_shr = load_sum >>> 2;

    assign pole_t = pole_reg[pole_idx];

    always_comb begin
        if (ctrl.op == llf_pkg::OP_MULP) begin
            mul_a = AW'(x_reg) - AW'(pole_t);
            mul_b = BW'(cutoff_reg);
        end else begin
            mul_a = AW'(x_reg);
            mul_b = $signed({1'b0, gain_reg});
        end
    end

    assign prod_w   = PW'(mul_a) * PW'(mul_b);
    assign rnd_full = prod_reg + RND_HALF;
    assign rnd_val  = rnd_full[PW-1:CF];

    // First clamp: new pole value
    assign sum1 = CW'(x_reg) + CW'(rnd_val);
    always_comb begin
        if (sum1 > LIM_POS) begin
            sat1 = LIM_POS;
        end else if (sum1 < LIM_NEG) begin
            sat1 = LIM_NEG;
        end else begin
            sat1 = sum1;
        end
    end
    assign pole_new = sat1[SB-1:0];

    // Second clamp: stage output adds the old pole
    assign sum2 = CW'(pole_new) + CW'(pole_t);
    always_comb begin
        if (sum2 > LIM_POS) begin
            sat2 = LIM_POS;
        end else if (sum2 < LIM_NEG) begin
            sat2 = LIM_NEG;
        end else begin
            sat2 = sum2;
        end
    end

    // Feedback saturates to the Q2 range
    assign fb_w = CW'(rnd_val);
    always_comb begin
        if (fb_w > FB_MAX) begin
            fb_sat = FB_MAX;
        end else if (fb_w < FB_MIN) begin
            fb_sat = FB_MIN;
        end else begin
            fb_sat = fb_w;
        end
    end
    assign fb_next = fb_sat[SB:0];

    always_comb begin
        x_next = x_reg;
        case (ctrl.op)
            llf_pkg::OP_LOAD: begin
                if (in_fire) begin
                    x_next = load_shr[SB-1:0];
                end
            end
            llf_pkg::OP_POLE: begin
                x_next = sat2[SB-1:0];
            end
            default: begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg    <= llf_pkg::CUTOFF_RESET;
            gain_reg      <= llf_pkg::GAIN_RESET;
            fb_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < POLE_COUNT; i++) begin
                pole_reg[i] <= '0;
            end
        end else begin
            if (cfg_fire && cfg_index == llf_pkg::REG_CUTOFF) begin
                cutoff_reg <= cfg_data;
            end
            if (cfg_fire && cfg_index == llf_pkg::REG_GAIN) begin
                gain_reg <= cfg_data;
            end
            if (ctrl.op == llf_pkg::OP_POLE) begin
                pole_reg[pole_idx] <= pole_new;
            end
            if (do_out) begin
                fb_reg        <= fb_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        if (ctrl.op == llf_pkg::OP_MULP || ctrl.op == llf_pkg::OP_MULQ) begin
            prod_reg <= prod_w;
        end
        if (do_out) begin
            out_reg <= x_reg;
        end
    end

endmodule

// ===== hw/rtl/ladder_lowpass_filter_unit.sv =====
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_unit
// POLE_COUNT-pole (default 4) ladder low-pass filter on signed Q1.(SAMPLE_BITS-1)
// samples, run by a microcoded sequencer over one shared multiplier.
//
//   channel  dir  handshake            payload
//   s_       in   s_valid / s_ready    s_sample_in
//   m_       out  m_valid / m_ready    m_sample_out
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each sample runs a load step, a multiply and an update step per pole,
// a feedback multiply and an output step; all multiplies go through the
// single multiplier and its product register.
// Reset clears poles and feedback and loads the coefficient defaults.
// A stalled result holds the sequencer in the output step only while the
// previous result still sits in the output register.
// Config beats are always taken.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_unit #(
    parameter int POLE_COUNT  = llf_pkg::POLE_COUNT_DEF,
    parameter int SAMPLE_BITS = llf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [llf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [llf_pkg::COEF_BITS-1:0]      cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out
);

    localparam int KW = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;

    llf_pkg::ucode_t ctrl;
    logic [KW-1:0]   pole_idx;
    logic            in_fire;
    logic            out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (ctrl.op == llf_pkg::OP_LOAD);
    assign in_fire   = s_valid && s_ready;

    llf_sequencer #(
        .POLE_COUNT (POLE_COUNT)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .ctrl     (ctrl),
        .pole_idx (pole_idx)
    );

    llf_datapath #(
        .POLE_COUNT  (POLE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_fire   (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .sample_in  (s_sample_in),
        .ctrl       (ctrl),
        .pole_idx   (pole_idx),
        .out_free   (out_free),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .sample_out (m_sample_out)
    );

`ifndef SYNTHESIS
    localparam longint LimChk = (95 * (longint'(1) <<< (SAMPLE_BITS - 1)) + 50) / 100;
    localparam logic signed [SAMPLE_BITS-1:0] LIM_CHK = SAMPLE_BITS'(LimChk);

    // results stay inside the clamp range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_out <= LIM_CHK && m_sample_out >= -LIM_CHK))
        else $error("result outside clamp range");

    // one input beat per pass through the program
    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input taken twice in a row");

    // pole counter never passes the last pole
    a_pole_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        pole_idx <= KW'(POLE_COUNT - 1))
        else $error("pole index out of range");

    // a finished result is never overwritten before it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
`endif

endmodule
